>>> rtl/core/heap_interleave_scheduler_core_assert.svh
// assertion macros for the heap interleave scheduler core
`ifndef HEAP_INTERLEAVE_SCHEDULER_CORE_ASSERT_SVH
`define HEAP_INTERLEAVE_SCHEDULER_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define HISC_ASSERT_HOLD(label, clk_s, rst_s, cond, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (cond)) else $error(msg);

// condition in the cycle after a trigger
`define HISC_ASSERT_NEXT(label, clk_s, rst_s, pre, post, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/core/hisc_pkg.sv
// shared codes and result types of the heap interleave scheduler
`timescale 1ns / 1ps
`default_nettype none

package hisc_pkg;

  localparam int ID_BITS = 10;

  // request kinds
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_NEXT  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic [ID_BITS-1:0] type_id;
    logic [1:0]         status;
    logic               last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

endpackage

`default_nettype wire

>>> rtl/core/heap_interleave_scheduler_core.sv
// top level of the heap interleave scheduler: max-heap of type counts in one memory
// usage:
//  s_axis carries one request per beat: tuser is the request kind (load, next, clear)
//  and tdata the count of a loaded type. m_axis carries results: tdata the type id,
//  tuser the status (ok, exhausted, full), tlast the final result of a request.
//  a load returns one result (assigned id or full); a next request returns one or
//  two ids, or exhausted; a clear returns nothing.
// timing:
//  the heap sits in a single memory with one read and one write port and a registered
//  read port; requests are handled one at a time by a sequencer.
//  load: its result is queued on the accept edge; sift-up alternates a parent read
//  (S_UP_RD) and a compare-and-write (S_UP_CMP) for each level moved.
//  next: slots 1, 2 and 3 are read, then results are queued in S_NX_DEC; each level
//  of a sift-down walk reads the left child, the right child, then compares and writes.
//  clear, or next on an empty heap: done on the accept, with no busy state.
// reset: entry count returns to zero and the result queue empties; memory contents
//  are not cleared; beyond the entry count only slots 2 and 3 are read, then ignored.
// stalls: results wait in a four-entry queue; a request is taken only when the
//  sequencer is idle and the queue has room for two results, so up to two waiting
//  results do not block the next request.
`timescale 1ns / 1ps
`default_nettype none

`include "heap_interleave_scheduler_core_assert.svh"

module heap_interleave_scheduler_core #(
  parameter int MAX_TYPES  = 1023,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] count
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [9:0] type_id, [15:10] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast    // last
);

  localparam int AW    = $clog2(MAX_TYPES + 1);
  localparam int DEPTH = MAX_TYPES + 1;
  localparam logic [AW-1:0] MAX_N  = AW'(MAX_TYPES);
  localparam logic [AW-1:0] SLOT1  = AW'(1);
  localparam logic [AW-1:0] SLOT2  = AW'(2);
  localparam logic [AW-1:0] SLOT3  = AW'(3);
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  typedef struct packed {
    logic [COUNT_BITS-1:0] cnt;
    logic [AW-1:0]         id;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_NX_R2,
    S_NX_R3,
    S_NX_DEC,
    S_DN_RL,
    S_DN_RR,
    S_DN_CMP
  } state_t;

  function automatic logic [hisc_pkg::ID_BITS-1:0] id_out(input logic [AW-1:0] v);
    logic [AW+hisc_pkg::ID_BITS-1:0] w;
    w = {{hisc_pkg::ID_BITS{1'b0}}, v};
    return w[hisc_pkg::ID_BITS-1:0];
  endfunction

  function automatic hisc_pkg::result_t mk_res(input logic [AW-1:0] id,
                                               input logic [1:0] st, input logic lst);
    hisc_pkg::result_t r;
    r.type_id = id_out(id);
    r.status  = st;
    r.last    = lst;
    return r;
  endfunction

  // state registers
  state_t        state;
  logic [AW-1:0] entry_count;
  entry_t        cur;          // element being sifted
  logic [AW-1:0] idx;          // its current slot
  entry_t        lchild;       // left child captured during sift-down
  logic          rvalid;       // right child was read
  entry_t        root;         // root captured at the start of a next request
  entry_t        e2;           // slot 2 captured
  logic          c2_live;      // slot 2 exists and is nonzero
  logic          root_pending; // root still to be decremented after the child walk

  // heap memory
  entry_t        mem [DEPTH];
  entry_t        rd_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // result queue
  hisc_pkg::push_t   push_a;
  hisc_pkg::push_t   push_b;
  hisc_pkg::result_t q_data;
  logic              q_room;

  hisc_out_queue u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .push_a  (push_a),
    .push_b  (push_b),
    .room2   (q_room),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_data  (q_data)
  );

  assign m_axis_tdata = {{(16 - hisc_pkg::ID_BITS){1'b0}}, q_data.type_id};
  assign m_axis_tuser = q_data.status;
  assign m_axis_tlast = q_data.last;

  // request decode
  logic                  in_acc;
  logic [31:0]           cnt_wide;
  logic [COUNT_BITS-1:0] load_cnt;
  logic                  heap_full;
  logic [AW-1:0]         new_slot;

  assign s_axis_tready = (state == S_IDLE) && q_room;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cnt_wide      = {16'b0, s_axis_tdata};
  assign load_cnt      = cnt_wide[COUNT_BITS-1:0];
  assign heap_full     = (entry_count == MAX_N);
  assign new_slot      = entry_count + SLOT1;

  // child addresses, one bit wider so the bound test cannot wrap
  logic [AW:0]   l_wide;
  logic [AW:0]   r_wide;
  logic          l_ok;
  logic          r_ok;
  logic [AW-1:0] l_addr;
  logic [AW-1:0] r_addr;
  logic [AW-1:0] parent;

  assign l_wide = {idx, 1'b0};
  assign r_wide = {idx, 1'b1};
  assign l_ok   = (l_wide <= {1'b0, entry_count});
  assign r_ok   = (r_wide <= {1'b0, entry_count});
  assign l_addr = l_wide[AW-1:0];
  assign r_addr = r_wide[AW-1:0];
  assign parent = idx >> 1;

  // sift-up compare: parent strictly smaller moves down
  logic up_move;
  assign up_move = (rd_q.cnt < cur.cnt);

  // sift-down compare: left tested first, right must strictly beat the best
  logic                  dn_sel_l;
  logic                  dn_sel_r;
  logic [COUNT_BITS-1:0] dn_best;
  logic                  dn_move;
  entry_t                dn_child;
  logic [AW-1:0]         dn_child_addr;

  assign dn_sel_l      = (lchild.cnt > cur.cnt);
  assign dn_best       = dn_sel_l ? lchild.cnt : cur.cnt;
  assign dn_sel_r      = rvalid && (rd_q.cnt > dn_best);
  assign dn_move       = dn_sel_l || dn_sel_r;
  assign dn_child      = dn_sel_r ? rd_q : lchild;
  assign dn_child_addr = dn_sel_r ? r_addr : l_addr;

  // next-request decision once slots 1..3 are in
  logic   c3_live;
  logic   child_case;
  entry_t z_ent;
  logic [AW-1:0] z_addr;

  assign c3_live    = (entry_count >= SLOT3) && (rd_q.cnt != '0);
  assign child_case = c2_live || c3_live;
  assign z_ent      = c2_live ? e2 : rd_q;
  assign z_addr     = c2_live ? SLOT2 : SLOT3;

  // end of a sift-down walk
  logic dn_done;
  assign dn_done = ((state == S_DN_RL) && !l_ok) || ((state == S_DN_CMP) && !dn_move);

  // memory and queue controls
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = SLOT1;
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = cur;
    push_a  = '0;
    push_b  = '0;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (s_axis_tuser)
            hisc_pkg::REQ_LOAD: begin
              push_a.valid = 1'b1;
              push_a.res   = heap_full ? mk_res('0, hisc_pkg::STAT_FULL, 1'b1)
                                       : mk_res(new_slot, hisc_pkg::STAT_OK, 1'b1);
            end
            hisc_pkg::REQ_NEXT: begin
              if (entry_count == '0) begin
                push_a.valid = 1'b1;
                push_a.res   = mk_res('0, hisc_pkg::STAT_EXHAUSTED, 1'b1);
              end else begin
                rd_en   = 1'b1;
                rd_addr = SLOT1;
              end
            end
            default: ;
          endcase
        end
      end
      S_UP_RD: begin
        if (idx == SLOT1) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = parent;
        end
      end
      S_UP_CMP: begin
        wr_en   = 1'b1;
        wr_data = up_move ? rd_q : cur;
      end
      S_NX_R2: begin
        rd_en   = 1'b1;
        rd_addr = SLOT2;
      end
      S_NX_R3: begin
        rd_en   = 1'b1;
        rd_addr = SLOT3;
      end
      S_NX_DEC: begin
        push_a.valid = 1'b1;
        if (child_case) begin
          push_a.res   = mk_res(root.id, hisc_pkg::STAT_OK, 1'b0);
          push_b.valid = 1'b1;
          push_b.res   = mk_res(z_ent.id, hisc_pkg::STAT_OK, 1'b1);
        end else if (root.cnt != '0) begin
          push_a.res = mk_res(root.id, hisc_pkg::STAT_OK, 1'b1);
        end else begin
          push_a.res = mk_res('0, hisc_pkg::STAT_EXHAUSTED, 1'b1);
        end
      end
      S_DN_RL: begin
        if (l_ok) begin
          rd_en   = 1'b1;
          rd_addr = l_addr;
        end else begin
          wr_en = 1'b1;
        end
      end
      S_DN_RR: begin
        if (r_ok) begin
          rd_en   = 1'b1;
          rd_addr = r_addr;
        end
      end
      S_DN_CMP: begin
        wr_en   = 1'b1;
        wr_data = dn_move ? dn_child : cur;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_count  <= '0;
      root_pending <= 1'b0;
      rvalid       <= 1'b0;
      c2_live      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (s_axis_tuser)
              hisc_pkg::REQ_LOAD: begin
                if (!heap_full) begin
                  entry_count <= new_slot;
                  cur.cnt     <= load_cnt;
                  cur.id      <= new_slot;
                  idx         <= new_slot;
                  state       <= S_UP_RD;
                end
              end
              hisc_pkg::REQ_NEXT: begin
                if (entry_count != '0) begin
                  state <= S_NX_R2;
                end
              end
              hisc_pkg::REQ_CLEAR: begin
                entry_count <= '0;
              end
              default: ;
            endcase
          end
        end
        S_UP_RD: begin
          state <= (idx == SLOT1) ? S_IDLE : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (up_move) begin
            idx   <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_NX_R2: begin
          root  <= rd_q;
          state <= S_NX_R3;
        end
        S_NX_R3: begin
          e2      <= rd_q;
          c2_live <= (entry_count >= SLOT2) && (rd_q.cnt != '0);
          state   <= S_NX_DEC;
        end
        S_NX_DEC: begin
          if (child_case) begin
            // chosen child first, root afterwards
            cur.cnt      <= z_ent.cnt - CNT_ONE;
            cur.id       <= z_ent.id;
            idx          <= z_addr;
            root_pending <= 1'b1;
            state        <= S_DN_RL;
          end else if (root.cnt != '0) begin
            cur.cnt      <= root.cnt - CNT_ONE;
            cur.id       <= root.id;
            idx          <= SLOT1;
            root_pending <= 1'b0;
            state        <= S_DN_RL;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DN_RL: begin
          if (l_ok) begin
            state <= S_DN_RR;
          end
        end
        S_DN_RR: begin
          lchild <= rd_q;
          rvalid <= r_ok;
          state  <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (dn_move) begin
            idx   <= dn_child_addr;
            state <= S_DN_RL;
          end
        end
        default: state <= S_IDLE;
      endcase

      // a finished walk either starts the root walk or returns to idle
      if (dn_done) begin
        root_pending <= 1'b0;
        if (root_pending && (root.cnt != '0)) begin
          cur.cnt <= root.cnt - CNT_ONE;
          cur.id  <= root.id;
          idx     <= SLOT1;
          state   <= S_DN_RL;
        end else begin
          state <= S_IDLE;
        end
      end
    end
  end

  // checks
  logic wr_in_live;
  logic rw_apart;
  logic load_take;

  assign wr_in_live = !wr_en || (wr_addr != '0 && wr_addr <= entry_count);
  assign rw_apart   = !(wr_en && rd_en) || (wr_addr != rd_addr);
  assign load_take  = in_acc && (s_axis_tuser == hisc_pkg::REQ_LOAD) && !heap_full;

  `HISC_ASSERT_HOLD(a_wr_live_slot, clk, rst, wr_in_live, "heap write outside live slots")
  `HISC_ASSERT_HOLD(a_no_rw_clash, clk, rst, rw_apart, "read and write hit the same slot")
  `HISC_ASSERT_NEXT(a_load_grows, clk, rst, load_take, entry_count == $past(new_slot), "load lost")

endmodule

`default_nettype wire

>>> rtl/core/hisc_out_queue.sv
// four-entry result queue with two push ports and a stream pop side
`timescale 1ns / 1ps
`default_nettype none

module hisc_out_queue (
  input  logic             clk,
  input  logic             rst,
  input  hisc_pkg::push_t  push_a,
  input  hisc_pkg::push_t  push_b,
  output logic             room2,
  output logic             m_valid,
  input  logic             m_ready,
  output hisc_pkg::result_t m_data
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  hisc_pkg::result_t q [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     fill;
  logic [CW-1:0]     n_push;
  logic              pop;

  assign pop     = m_valid && m_ready;
  assign m_valid = (fill != '0);
  assign m_data  = q[rd_ptr];
  assign room2   = (fill <= CW'(DEPTH - 2));
  assign n_push  = CW'(push_a.valid) + CW'(push_b.valid);

  // push_b is only used together with push_a
  always_ff @(posedge clk) begin
    if (push_a.valid) begin
      q[wr_ptr] <= push_a.res;
    end
    if (push_b.valid) begin
      q[wr_ptr + PW'(1)] <= push_b.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[PW-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      fill <= fill + n_push - CW'(pop);
    end
  end

endmodule

`default_nettype wire
